>>> rtl/e2k_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2k_pkg
// Shared widths, constants and the CORDIC step-angle table for the
// equinoctial-to-Keplerian converter.
// ----------------------------------------------------------------------------
package e2k_pkg;

   localparam int ANGLE_BITS_DEF = 32;
   localparam int CORDIC_STEPS   = 60;
   localparam int DIV_STEPS      = 128;
   localparam int SQRT_STEPS     = 32;
   localparam logic [63:0] ONE_Q60  = 64'h1000_0000_0000_0000;
   localparam logic [63:0] PI_Q62   = 64'hC90F_DAA2_2168_C235;
   localparam logic [47:0] AXIS_MAX = 48'h7FFF_FFFF_FFFF;

   // atan(2^-i) / (2 pi) as a Q.64 turn; built by constant evaluation
   function automatic logic [63:0] step_turn(input int i);
      logic [63:0]  rad;
      logic [127:0] num;
      logic [63:0]  r;
      logic [63:0]  q;
      logic         top;
      logic         sat;
      int           sh;
      rad = '0;
      r   = '0;
      q   = '0;
      sat = 1'b0;
      if (i == 0) begin
         return 64'h2000_0000_0000_0000;
      end
      for (int n = 0; n < 32; n++) begin
         sh = (2 * n + 1) * i;
         if (sh <= 63) begin
            if (n % 2 == 1) begin
               rad = rad - ((64'd1 << (64 - sh)) / 64'(2 * n + 1));
            end else begin
               rad = rad + ((64'd1 << (64 - sh)) / 64'(2 * n + 1));
            end
         end
      end
      num = {rad >> 3, rad << 61};
      for (int b = 127; b >= 0; b--) begin
         top = r[63];
         r   = {r[62:0], num[b]};
         if (q[63]) begin
            sat = 1'b1;
         end
         q = {q[62:0], 1'b0};
         if (top || r >= PI_Q62) begin
            r    = r - PI_Q62;
            q[0] = 1'b1;
         end
      end
      return sat ? '1 : q;
   endfunction

endpackage : e2k_pkg
`default_nettype wire

>>> rtl/e2k_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2k_cordic
// Pipelined vectoring CORDIC: one micro-rotation per stage, returns the
// angle of (x, y) as a 64-bit turn fraction. Zero vector gives zero.
// ----------------------------------------------------------------------------
module e2k_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic signed [32:0] x_in,
   input  wire logic signed [32:0] y_in,
   output logic             [63:0] turn
);

   localparam int N = e2k_pkg::CORDIC_STEPS;

   // 33-bit operands scaled by 2^28 plus growth headroom
   logic signed [63:0] x_ff [N+1];
   logic signed [63:0] y_ff [N+1];
   logic        [63:0] z_ff [N+1];
   logic               zero_ff [N+1];

   logic signed [63:0] xs_in;
   logic signed [63:0] ys_in;

   // Scale the operands; the input register folds the left half-plane over before the steps
   always_comb begin
      xs_in = 64'(x_in) <<< 28;
      ys_in = 64'(y_in) <<< 28;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         if (x_in < 0) begin
            x_ff[0] <= -xs_in;
            y_ff[0] <= -ys_in;
            z_ff[0] <= 64'h8000_0000_0000_0000;
         end else begin
            x_ff[0] <= xs_in;
            y_ff[0] <= ys_in;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      localparam logic [63:0] STEP = e2k_pkg::step_turn(i);
      always_ff @(posedge clock) begin
         if (advance) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + STEP;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - STEP;
            end
         end
      end
   end

   assign turn = zero_ff[N] ? '0 : z_ff[N];

   logic unused_reset;
   assign unused_reset = reset;

endmodule : e2k_cordic
`default_nettype wire

>>> rtl/equinoctial_to_keplerian.sv
`default_nettype none
// ----------------------------------------------------------------------------
// equinoctial_to_keplerian
// Converts modified equinoctial elements to Keplerian elements, one word
// per cycle while rsp is not stalled, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)                        | tuser
//  req     | in  | semi_latus, ecc_x, ecc_y, node_x, node_y, true_long   | -
//  rsp     | out | semi_major, eccentricity, inclination, periapsis_arg, | axis_undefined
//          |     | node_longitude, true_anomaly                          |
//
// One word enters per cycle unless rsp stalls; the word passes one unpack/square
// stage, then the 128-stage restoring divider, then the output register, and
// rsp_tvalid rises with it. The divider depth sets the latency.
// The square roots (32 stages) and the CORDICs (61 stages) finish at stage
// 94 and their results wait 35 stages in a delay line.
// Reset clears every valid bit; payload registers are not reset.
// A stall on rsp freezes the whole pipe; nothing is lost or repeated, and
// req_tready stays high while the output slot is empty or being drained.
// ----------------------------------------------------------------------------
module equinoctial_to_keplerian #(
   parameter int ANGLE_BITS = e2k_pkg::ANGLE_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // semi_latus[31:0] ecc_x[63:32] ecc_y[95:64] node_x[127:96]
   // node_y[159:128] true_longitude[191:160]
   input  wire logic [191:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // semi_major[47:0] eccentricity[79:48] inclination[111:80]
   // periapsis_arg[143:112] node_longitude[175:144] true_anomaly[207:176]
   output logic      [207:0] rsp_tdata,
   // axis_undefined[0]
   output logic              rsp_tuser
);

   localparam int SQ   = e2k_pkg::SQRT_STEPS;
   localparam int CD   = e2k_pkg::CORDIC_STEPS + 1;
   localparam int DV   = e2k_pkg::DIV_STEPS;
   localparam int LAT  = DV + 1;               // stage 0, then the divider
   localparam int APAD = LAT - (SQ + 1 + CD);  // angle results wait this long
   localparam int SH   = 64 - ANGLE_BITS;

   // Global enable: the pipe moves when the output slot can take a word
   logic advance;
   logic valid_ff [LAT+1];
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // ---------------- stage 0: unpack, square --------------------------------
   logic        [31:0] p_ff, l_ff;
   logic signed [31:0] f_ff, g_ff, h_ff, k_ff;
   logic        [63:0] e2_ff, hk_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff  <= req_tdata[31:0];
         f_ff  <= req_tdata[63:32];
         g_ff  <= req_tdata[95:64];
         h_ff  <= req_tdata[127:96];
         k_ff  <= req_tdata[159:128];
         l_ff  <= req_tdata[191:160];
         e2_ff <= 64'($signed(req_tdata[63:32]) * $signed(req_tdata[63:32]))
                + 64'($signed(req_tdata[95:64]) * $signed(req_tdata[95:64]));
         hk_ff <= 64'($signed(req_tdata[127:96]) * $signed(req_tdata[127:96]))
                + 64'($signed(req_tdata[159:128]) * $signed(req_tdata[159:128]));
      end
   end

   // ---------------- square roots: one result bit per stage -----------------
   logic [63:0] sv_ff [SQ+1], sr_ff [SQ+1], sb_ff [SQ+1];   // e2
   logic [63:0] hv_ff [SQ+1], hr_ff [SQ+1];                 // h^2+k^2
   assign sv_ff[0] = e2_ff;
   assign sr_ff[0] = '0;
   assign sb_ff[0] = 64'd1 << 62;
   assign hv_ff[0] = hk_ff;
   assign hr_ff[0] = '0;

   for (genvar i = 0; i < SQ; i++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (advance) begin
            sb_ff[i+1] <= sb_ff[i] >> 2;
            if (sv_ff[i] >= sr_ff[i] + sb_ff[i]) begin
               sv_ff[i+1] <= sv_ff[i] - (sr_ff[i] + sb_ff[i]);
               sr_ff[i+1] <= (sr_ff[i] >> 1) + sb_ff[i];
            end else begin
               sv_ff[i+1] <= sv_ff[i];
               sr_ff[i+1] <= sr_ff[i] >> 1;
            end
            if (hv_ff[i] >= hr_ff[i] + sb_ff[i]) begin
               hv_ff[i+1] <= hv_ff[i] - (hr_ff[i] + sb_ff[i]);
               hr_ff[i+1] <= (hr_ff[i] >> 1) + sb_ff[i];
            end else begin
               hv_ff[i+1] <= hv_ff[i];
               hr_ff[i+1] <= hr_ff[i] >> 1;
            end
         end
      end
   end

   // ---------------- delay lines for operands ------------------------------
   logic signed [31:0] fd_ff [SQ+1], gd_ff [SQ+1], hd_ff [SQ+1], kd_ff [SQ+1];
   logic        [31:0] ld_ff [SQ+CD+1];
   logic        [31:0] ed_ff [CD+1];
   assign fd_ff[0] = f_ff;
   assign gd_ff[0] = g_ff;
   assign hd_ff[0] = h_ff;
   assign kd_ff[0] = k_ff;
   assign ld_ff[0] = l_ff;
   assign ed_ff[0] = sr_ff[SQ][31:0];

   for (genvar i = 0; i < SQ; i++) begin : g_opd
      always_ff @(posedge clock) begin
         if (advance) begin
            fd_ff[i+1] <= fd_ff[i];
            gd_ff[i+1] <= gd_ff[i];
            hd_ff[i+1] <= hd_ff[i];
            kd_ff[i+1] <= kd_ff[i];
         end
      end
   end
   for (genvar i = 0; i < SQ + CD; i++) begin : g_ld
      always_ff @(posedge clock) begin
         if (advance) begin
            ld_ff[i+1] <= ld_ff[i];
         end
      end
   end
   for (genvar i = 0; i < CD; i++) begin : g_ed
      always_ff @(posedge clock) begin
         if (advance) begin
            ed_ff[i+1] <= ed_ff[i];
         end
      end
   end

   // ---------------- CORDICs ------------------------------------------------
   logic [63:0] inc_turn, w_turn, node_turn;
   logic        circ_ff [CD+1];
   assign circ_ff[0] = (fd_ff[SQ] == '0) && (gd_ff[SQ] == '0);
   for (genvar i = 0; i < CD; i++) begin : g_circ
      always_ff @(posedge clock) begin
         if (advance) begin
            circ_ff[i+1] <= circ_ff[i];
         end
      end
   end

   // Result of the h,k root fits in 32 bits (floor of sqrt of at most 2^63)
   e2k_cordic u_inc (
      .clock (clock), .reset (reset), .advance (advance),
      .x_in  (33'sd16777216),
      .y_in  ($signed({1'b0, hr_ff[SQ][31:0]})),
      .turn  (inc_turn)
   );
   e2k_cordic u_arg (
      .clock (clock), .reset (reset), .advance (advance),
      .x_in  (33'(fd_ff[SQ])), .y_in (33'(gd_ff[SQ])),
      .turn  (w_turn)
   );
   e2k_cordic u_node (
      .clock (clock), .reset (reset), .advance (advance),
      .x_in  (33'(hd_ff[SQ])), .y_in (33'(kd_ff[SQ])),
      .turn  (node_turn)
   );

   // ---------------- divider: one quotient bit per stage --------------------
   // Runs from stage 1 for DV stages; its result meets the output register.
   logic [63:0]  dd_ff [DV+1], dr_ff [DV+1], dq_ff [DV+1];
   logic [127:0] dn_ff [DV+1];
   logic         ds_ff [DV+1], dneg_ff [DV+1], dflag_ff [DV+1];
   logic         top [DV];
   logic [63:0]  rsh [DV];

   assign dn_ff[0]    = {36'd0, p_ff, 60'd0};
   assign dd_ff[0]    = (e2_ff > e2k_pkg::ONE_Q60) ? e2_ff - e2k_pkg::ONE_Q60
                                                   : e2k_pkg::ONE_Q60 - e2_ff;
   assign dr_ff[0]    = '0;
   assign dq_ff[0]    = '0;
   assign ds_ff[0]    = 1'b0;
   assign dneg_ff[0]  = e2_ff > e2k_pkg::ONE_Q60;
   assign dflag_ff[0] = e2_ff == e2k_pkg::ONE_Q60;

   for (genvar i = 0; i < DV; i++) begin : g_div
      assign top[i] = dr_ff[i][63];
      assign rsh[i] = {dr_ff[i][62:0], dn_ff[i][127]};
      always_ff @(posedge clock) begin
         if (advance) begin
            dn_ff[i+1]    <= dn_ff[i] << 1;
            dd_ff[i+1]    <= dd_ff[i];
            dneg_ff[i+1]  <= dneg_ff[i];
            dflag_ff[i+1] <= dflag_ff[i];
            ds_ff[i+1]    <= ds_ff[i] | dq_ff[i][63];
            if (top[i] || rsh[i] >= dd_ff[i]) begin
               dr_ff[i+1] <= rsh[i] - dd_ff[i];
               dq_ff[i+1] <= {dq_ff[i][62:0], 1'b1};
            end else begin
               dr_ff[i+1] <= rsh[i];
               dq_ff[i+1] <= {dq_ff[i][62:0], 1'b0};
            end
         end
      end
   end

   // Saturate and sign the quotient
   logic [63:0] q_sat;
   logic [47:0] a_val;
   always_comb begin
      q_sat = ds_ff[DV] ? '1 : dq_ff[DV];
      if (dflag_ff[DV]) begin
         a_val = e2k_pkg::AXIS_MAX;
      end else if (!dneg_ff[DV]) begin
         a_val = (q_sat > 64'(e2k_pkg::AXIS_MAX)) ? e2k_pkg::AXIS_MAX : q_sat[47:0];
      end else begin
         a_val = (q_sat > 64'(e2k_pkg::AXIS_MAX) + 64'd1) ? 48'h8000_0000_0000
                                                          : 48'(64'd0 - q_sat);
      end
   end

   localparam int DPAD = LAT - 1 - DV;   // stage 0 at index 1, divider 1+DV
   logic [48:0] ad_ff [DPAD+1];
   assign ad_ff[0] = {dflag_ff[DV], a_val};
   for (genvar i = 0; i < DPAD; i++) begin : g_ad
      always_ff @(posedge clock) begin
         if (advance) begin
            ad_ff[i+1] <= ad_ff[i];
         end
      end
   end

   // ---------------- valid chain and output slot ----------------------------
   assign valid_ff[0] = req_tvalid;
   for (genvar i = 0; i < LAT; i++) begin : g_vld
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end
   end

   logic [63:0] inc2, wm, lm;
   assign inc2 = inc_turn << 1;
   assign wm   = w_turn - node_turn;
   assign lm   = (64'(ld_ff[SQ+CD]) << SH) - w_turn;

   // Hold the finished angle fields and eccentricity until the divider is done
   // eccentricity[31:0] inclination[63:32] periapsis_arg[95:64]
   // node_longitude[127:96] true_anomaly[159:128]
   logic [159:0] pd_ff [APAD+1];
   assign pd_ff[0] = {32'(lm >> SH), 32'(node_turn >> SH),
                      circ_ff[CD] ? 32'd0 : 32'(wm >> SH),
                      32'(inc2 >> SH), ed_ff[CD]};
   for (genvar i = 0; i < APAD; i++) begin : g_pd
      always_ff @(posedge clock) begin
         if (advance) begin
            pd_ff[i+1] <= pd_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (advance) begin
         rsp_tvalid <= valid_ff[LAT];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata[47:0]   <= ad_ff[DPAD][47:0];
         rsp_tdata[207:48] <= pd_ff[APAD];
         rsp_tuser         <= ad_ff[DPAD][48];
      end
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output slot");
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[47:0] == e2k_pkg::AXIS_MAX)
      else $error("undefined axis not saturated");
`endif

endmodule : equinoctial_to_keplerian
`default_nettype wire
